@@ hdl/gated_sine_tone_generator_core_assert.svh @@
// assertion macros shared by the tone generator rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef GATED_SINE_TONE_GENERATOR_CORE_ASSERT_SVH
`define GATED_SINE_TONE_GENERATOR_CORE_ASSERT_SVH

// condition must never hold outside reset
`define GSTG_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

// antecedent in one cycle implies consequent in the next
`define GSTG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gstg_pkg.sv @@
// shared types, constants and sine table builder for the tone generator
// no dependencies
package gstg_pkg;

  // field widths
  localparam int FRAME_W    = 40;
  localparam int INC_W      = 32;
  localparam int CNT_REG_W  = 4;
  localparam int CH_W       = 4;
  localparam int OUT_CH_W   = 3;
  localparam int SMP_W      = 16;

  // phase and table geometry
  localparam int PH_W       = 32;
  localparam int TAB_DEPTH  = 256;
  localparam int TAB_BITS   = $clog2(TAB_DEPTH);
  localparam int IDX_W      = TAB_BITS + 1;
  localparam int QTR_SH     = PH_W - 2;
  localparam int IDX_LO     = QTR_SH - TAB_BITS;
  localparam int FRAC_W     = 16;
  localparam int TAB_VAL_W  = SMP_W - 1;

  // table builder constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int Q30_SH   = 30;
  localparam int ROUND_SH = 31 - SMP_W;
  localparam longint SMP_MAX = (longint'(1) <<< (SMP_W - 1)) - 1;
  localparam longint unsigned TAYLOR_DIV [6] = '{6, 20, 42, 72, 110, 156};

  // queue between front and back
  localparam int Q_DEPTH  = 8;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int USED_W   = $clog2(Q_DEPTH + 1);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 8'd3;

  // classified frame leaving the front
  typedef struct packed {
    logic               in_win;
    logic [FRAME_W-1:0] rendered;
    logic [CH_W-1:0]    last_ch;
  } front_item_t;

  // frame with its sample, held in the queue
  typedef struct packed {
    logic               in_win;
    logic [FRAME_W-1:0] rendered;
    logic [CH_W-1:0]    last_ch;
    logic [SMP_W-1:0]   sample;
  } q_item_t;

  // quarter-wave entry k: taylor series in q30, rounded and saturated
  function automatic logic [TAB_VAL_W-1:0] sine_entry(input int k);
    longint unsigned x;
    longint unsigned term;
    longint sum;
    longint v;
    int n;
    x = (HALF_PI_Q30 * longint'(k)) / TAB_DEPTH;
    term = x;
    sum = longint'(x);
    for (n = 1; n <= 6; n++) begin
      term = (term * x) >> Q30_SH;
      term = ((term * x) >> Q30_SH) / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    v = (sum + (longint'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (v > SMP_MAX) v = SMP_MAX;
    return v[TAB_VAL_W-1:0];
  endfunction

endpackage

@@ hdl/gstg_front.sv @@
// front: accepts frame words, checks the tone window, keeps queue credits
// depends on gstg_pkg
`include "gated_sine_tone_generator_core_assert.svh"
module gstg_front #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gstg_pkg::FRAME_W-1:0]  frame_index,
  input  logic [gstg_pkg::FRAME_W-1:0]  start_frame,
  input  logic [gstg_pkg::FRAME_W-1:0]  duration_frames,
  input  logic [gstg_pkg::CNT_REG_W-1:0] channel_count,
  input  logic                          pop,
  output logic                          item_valid,
  output gstg_pkg::front_item_t         item
);
  import gstg_pkg::*;

  logic                  accept;
  logic                  before_win;
  logic [FRAME_W-1:0]    offset;
  logic                  in_win;
  logic [CH_W-1:0]       last_ch;
  logic [USED_W-1:0]     used_r, used_nxt;
  logic                  valid_r;
  front_item_t           item_r, item_nxt;

  // credits cover frames in flight and frames in the queue
  assign busy   = (used_r >= USED_W'(Q_DEPTH));
  assign accept = start && !busy;

  always_comb begin
    used_nxt = used_r;
    if (accept && !pop) used_nxt = used_r + USED_W'(1);
    else if (!accept && pop) used_nxt = used_r - USED_W'(1);
  end

  // window check
  assign before_win = (frame_index < start_frame);
  assign offset     = frame_index - start_frame;
  assign in_win     = !before_win && (offset < duration_frames);

  // channel count clamped to one..max
  always_comb begin
    if (channel_count == '0) last_ch = '0;
    else if (int'(channel_count) > MAX_CHANNELS) last_ch = CH_W'(MAX_CHANNELS - 1);
    else last_ch = CH_W'(channel_count - CNT_REG_W'(1));
  end

  always_comb begin
    item_nxt.in_win  = in_win;
    item_nxt.last_ch = last_ch;
    if (before_win) item_nxt.rendered = '0;
    else if (in_win) item_nxt.rendered = offset;
    else item_nxt.rendered = duration_frames;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      used_r  <= used_nxt;
      valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

  `GSTG_ASSERT_NEVER(a_credit_bound, used_r > USED_W'(Q_DEPTH), "credit count over queue depth")

endmodule

@@ hdl/gstg_sine.sv @@
// sine unit: phase multiply, quarter-wave lookup and interpolation in four stages
// depends on gstg_pkg
module gstg_sine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [gstg_pkg::INC_W-1:0]  phase_increment,
  input  logic                        in_valid,
  input  gstg_pkg::front_item_t       in_item,
  output logic                        out_valid,
  output gstg_pkg::q_item_t           out_item
);
  import gstg_pkg::*;

  logic [TAB_VAL_W-1:0] sine_tab [TAB_DEPTH+1];

  logic [3:0]           vld_r;
  front_item_t          it1_r, it2_r, it3_r;
  q_item_t              it4_r;

  logic [PH_W-1:0]      ph_nxt, ph_r;
  logic [1:0]           quad;
  logic [QTR_SH:0]      r_pos;
  logic [IDX_W-1:0]     idx, idx_hi;
  logic [TAB_VAL_W-1:0] t0, t1;
  logic [FRAC_W-1:0]    frac_nxt, frac_r;
  logic [TAB_VAL_W-1:0] base2_r, base3_r, dmag_nxt, dmag_r;
  logic                 dneg2_r, dneg3_r, neg2_r, neg3_r;
  logic [TAB_VAL_W+FRAC_W-1:0] prod;
  logic [TAB_VAL_W-1:0] pv_r;
  logic [TAB_VAL_W-1:0] mag;
  logic [SMP_W-1:0]     smp;

  // constant quarter-wave table
  for (genvar k = 0; k <= TAB_DEPTH; k++) begin : g_tab
    assign sine_tab[k] = sine_entry(k);
  end

  // stage 1: phase = offset times increment, modulo one cycle
  assign ph_nxt = in_item.rendered[PH_W-1:0] * PH_W'(phase_increment);

  // stage 2: quadrant fold and table read
  assign quad  = ph_r[PH_W-1 -: 2];
  always_comb begin
    if (quad[0]) r_pos = (QTR_SH+1)'(1) << QTR_SH;
    else r_pos = '0;
    if (quad[0]) r_pos = r_pos - {1'b0, ph_r[QTR_SH-1:0]};
    else r_pos = {1'b0, ph_r[QTR_SH-1:0]};
  end
  assign idx      = r_pos[QTR_SH -: IDX_W];
  assign frac_nxt = r_pos[IDX_LO-1 -: FRAC_W];
  assign idx_hi   = (idx == IDX_W'(TAB_DEPTH)) ? idx : idx + IDX_W'(1);
  assign t0       = sine_tab[idx];
  assign t1       = sine_tab[idx_hi];
  assign dmag_nxt = (t1 >= t0) ? (t1 - t0) : (t0 - t1);

  // stage 3: scale the step by the fraction
  assign prod = dmag_r * frac_r;

  // stage 4: interpolate and apply sign
  assign mag = dneg3_r ? (base3_r - pv_r) : (base3_r + pv_r);
  assign smp = neg3_r ? (SMP_W'(0) - {1'b0, mag}) : {1'b0, mag};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    it1_r   <= in_item;
    ph_r    <= ph_nxt;
    it2_r   <= it1_r;
    base2_r <= t0;
    dmag_r  <= dmag_nxt;
    dneg2_r <= (t1 < t0);
    frac_r  <= frac_nxt;
    neg2_r  <= quad[1];
    it3_r   <= it2_r;
    base3_r <= base2_r;
    dneg3_r <= dneg2_r;
    neg3_r  <= neg2_r;
    pv_r    <= prod[TAB_VAL_W+FRAC_W-1 -: TAB_VAL_W];
    it4_r.in_win   <= it3_r.in_win;
    it4_r.rendered <= it3_r.rendered;
    it4_r.last_ch  <= it3_r.last_ch;
    it4_r.sample   <= smp;
  end

  assign out_valid = vld_r[3];
  assign out_item  = it4_r;

endmodule

@@ hdl/gstg_fifo.sv @@
// short queue of finished frame words between front and back
// depends on gstg_pkg
`include "gated_sine_tone_generator_core_assert.svh"
module gstg_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gstg_pkg::q_item_t   push_item,
  input  logic                pop,
  output logic                head_valid,
  output gstg_pkg::q_item_t   head_item
);
  import gstg_pkg::*;

  q_item_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [USED_W-1:0]    count_r, count_nxt;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + USED_W'(1);
    else if (!push && pop) count_nxt = count_r - USED_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_item;
  end

  assign head_valid = (count_r != '0);
  assign head_item  = mem[rd_ptr_r];

  `GSTG_ASSERT_NEVER(a_no_overflow, push && !pop && (count_r == USED_W'(Q_DEPTH)), "queue overflow")
  `GSTG_ASSERT_NEVER(a_no_underflow, pop && (count_r == '0), "queue pop while empty")

endmodule

@@ hdl/gstg_emit.sv @@
// back: takes frame words from the queue and sends one result per cycle while words wait there
// depends on gstg_pkg
`include "gated_sine_tone_generator_core_assert.svh"
module gstg_emit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  gstg_pkg::q_item_t               head_item,
  output logic                            pop,
  output logic                            out_strobe,
  output logic signed [gstg_pkg::SMP_W-1:0] out_sample_value,
  output logic [gstg_pkg::OUT_CH_W-1:0]   out_channel,
  output logic                            out_in_window,
  output logic [gstg_pkg::FRAME_W-1:0]    out_frames_rendered,
  output logic                            out_last
);
  import gstg_pkg::*;

  logic                strobe_r, strobe_nxt;
  logic                last_r, last_nxt;
  logic [CH_W-1:0]     ch_r, ch_nxt;
  logic [CH_W-1:0]     last_ch_r, last_ch_nxt;
  logic [SMP_W-1:0]    sample_r, sample_nxt;
  logic                in_win_r, in_win_nxt;
  logic [FRAME_W-1:0]  rendered_r, rendered_nxt;
  logic                advance;

  // step through channels, then load the next frame with no gap
  assign advance = strobe_r && !last_r;
  assign pop     = !advance && head_valid;

  always_comb begin
    strobe_nxt   = 1'b0;
    last_nxt     = last_r;
    ch_nxt       = ch_r;
    last_ch_nxt  = last_ch_r;
    sample_nxt   = sample_r;
    in_win_nxt   = in_win_r;
    rendered_nxt = rendered_r;
    if (advance) begin
      strobe_nxt = 1'b1;
      ch_nxt     = ch_r + CH_W'(1);
      last_nxt   = ((ch_r + CH_W'(1)) == last_ch_r);
    end else if (head_valid) begin
      strobe_nxt   = 1'b1;
      ch_nxt       = '0;
      last_ch_nxt  = head_item.last_ch;
      last_nxt     = !head_item.in_win || (head_item.last_ch == '0);
      sample_nxt   = head_item.in_win ? head_item.sample : '0;
      in_win_nxt   = head_item.in_win;
      rendered_nxt = head_item.rendered;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      ch_r     <= '0;
    end else begin
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
      ch_r     <= ch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last_ch_r  <= last_ch_nxt;
    sample_r   <= sample_nxt;
    in_win_r   <= in_win_nxt;
    rendered_r <= rendered_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_sample_value    = sample_r;
  assign out_channel         = ch_r[OUT_CH_W-1:0];
  assign out_in_window       = in_win_r;
  assign out_frames_rendered = rendered_r;
  assign out_last            = last_r;

  `GSTG_ASSERT_NEXT(a_frame_continues, strobe_r && !last_r, strobe_r, "frame cut before last channel")

endmodule

@@ hdl/gated_sine_tone_generator_core.sv @@
// top level of the gated sine tone generator: config registers and wiring
// depends on gstg_pkg, gstg_front, gstg_sine, gstg_fifo, gstg_emit
//
// channel   handshake              word
// -------   ---------------------  ------------------------------------------
// input     start high, busy low   in_frame_index
// result    out_strobe, one cycle  sample_value, channel, in_window,
//                                  frames_rendered, last
// config    cfg_we                 cfg_index selects register, cfg_data value
//
// an accepted frame passes the front register, the sine stages and the queue before its first result is registered
// a frame in the window gives one result per channel, others give a single result
// the result port sends one result per cycle while frame words wait; it is the rate limit
// busy rises when eight frames are in flight or queued
// reset is synchronous, active low; config registers return to defaults
module gated_sine_tone_generator_core #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [gstg_pkg::FRAME_W-1:0]      in_frame_index,
  input  logic                              cfg_we,
  input  logic [gstg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gstg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              out_strobe,
  output logic signed [gstg_pkg::SMP_W-1:0] out_sample_value,
  output logic [gstg_pkg::OUT_CH_W-1:0]     out_channel,
  output logic                              out_in_window,
  output logic [gstg_pkg::FRAME_W-1:0]      out_frames_rendered,
  output logic                              out_last
);
  import gstg_pkg::*;

  logic [FRAME_W-1:0]   start_frame_r;
  logic [FRAME_W-1:0]   duration_r;
  logic [INC_W-1:0]     phase_inc_r;
  logic [CNT_REG_W-1:0] chan_cnt_r;

  logic                 front_valid;
  front_item_t          front_item;
  logic                 sine_valid;
  q_item_t              sine_item;
  logic                 head_valid;
  q_item_t              head_item;
  logic                 pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_frame_r <= '0;
      duration_r    <= '0;
      phase_inc_r   <= '0;
      chan_cnt_r    <= CNT_REG_W'(2);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START:    start_frame_r <= cfg_data[FRAME_W-1:0];
        CFG_DURATION: duration_r    <= cfg_data[FRAME_W-1:0];
        CFG_PHASE:    phase_inc_r   <= cfg_data[INC_W-1:0];
        CFG_CHANNELS: chan_cnt_r    <= cfg_data[CNT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify
  gstg_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .frame_index     (in_frame_index),
    .start_frame     (start_frame_r),
    .duration_frames (duration_r),
    .channel_count   (chan_cnt_r),
    .pop             (pop),
    .item_valid      (front_valid),
    .item            (front_item)
  );

  // sine pipeline
  gstg_sine u_sine (
    .clk             (clk),
    .rst_n           (rst_n),
    .phase_increment (phase_inc_r),
    .in_valid        (front_valid),
    .in_item         (front_item),
    .out_valid       (sine_valid),
    .out_item        (sine_item)
  );

  // queue between front and back
  gstg_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (sine_valid),
    .push_item  (sine_item),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: per-channel results
  gstg_emit u_emit (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_valid          (head_valid),
    .head_item           (head_item),
    .pop                 (pop),
    .out_strobe          (out_strobe),
    .out_sample_value    (out_sample_value),
    .out_channel         (out_channel),
    .out_in_window       (out_in_window),
    .out_frames_rendered (out_frames_rendered),
    .out_last            (out_last)
  );

endmodule
